// ===== rtl/core/mset_pkg.sv =====
// Shared types and codes for the multi-slot event timer table.
// Used by mset_cell and multi_slot_event_timer_table_unit; no dependencies.
package mset_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int CNT_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  localparam logic [1:0] ACT_SET     = 2'd0;
  localparam logic [1:0] ACT_KILL    = 2'd1;
  localparam logic [1:0] ACT_POLL    = 2'd2;
  localparam logic [1:0] ACT_CLEANUP = 2'd3;

  localparam logic [2:0] KIND_SET       = 3'd0;
  localparam logic [2:0] KIND_KILL      = 3'd1;
  localparam logic [2:0] KIND_FIRE      = 3'd2;
  localparam logic [2:0] KIND_POLL_DONE = 3'd3;
  localparam logic [2:0] KIND_CLEANUP   = 3'd4;

  typedef struct packed {
    logic        used;
    logic [15:0] owner;
    logic [31:0] id;
    logic [31:0] delay;
    logic [31:0] deadline;
    logic [31:0] callback;
    logic [31:0] user;
    logic        periodic;
  } slot_t;

endpackage

// ===== rtl/core/mset_cell.sv =====
// One timer slot of the ring; takes its neighbor's slot on every shift.
// Depends on mset_pkg.
module mset_cell
  import mset_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q = slot;

endmodule

// ===== rtl/core/multi_slot_event_timer_table_unit.sv =====
// Multi-slot event timer table: a ring of TIMER_SLOTS cells rotated past one head unit.
// The closing result is loaded in ST_DONE after one full rotation in ST_SCAN; a fire or closing
// result holds while the output register is full.
// A new item is accepted only in ST_IDLE; the input reopens after the close.
// Reset (rst, synchronous): all slots cleared, next id one, output empty.
// Depends on mset_pkg and mset_cell.
module multi_slot_event_timer_table_unit
  import mset_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // owner, now_ms, delay_ms, periodic, callback_value, user_value, target_id
  input  logic [183:0] s_tdata,
  // action
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // timer_id, fired_callback, fired_user, status
  output logic [103:0] m_tdata,
  // kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic             done;
  logic             done_next;
  logic [31:0]      next_id;
  logic [31:0]      next_id_next;
  logic [31:0]      res_id;
  logic [31:0]      res_id_next;

  logic [1:0]  req_action;
  logic [15:0] req_owner;
  logic [31:0] req_now;
  logic [31:0] req_delay;
  logic        req_periodic;
  logic [31:0] req_callback;
  logic [31:0] req_user;
  logic [31:0] req_target;
  logic        req_ok;

  logic         out_valid;
  logic [2:0]   out_kind;
  logic [31:0]  out_id;
  logic [31:0]  out_cb;
  logic [31:0]  out_user;
  logic         out_status;
  logic         out_last;
  logic         out_free;
  logic         out_load;
  logic [2:0]   out_kind_next;
  logic [31:0]  out_id_next;
  logic [31:0]  out_cb_next;
  logic [31:0]  out_user_next;
  logic         out_status_next;
  logic         out_last_next;

  slot_t ring_q [TIMER_SLOTS];
  slot_t head_out;
  slot_t head_in;
  logic  shift;
  logic  advance;
  logic  owner_hit;
  logic  due;
  logic [31:0] id_take;
  logic [31:0] age;

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_ring
      slot_t cell_d;
      if (g == TIMER_SLOTS - 1) begin : g_tail
        assign cell_d = head_out;
      end else begin : g_mid
        assign cell_d = ring_q[g+1];
      end
      mset_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (cell_d),
        .q     (ring_q[g])
      );
    end
  endgenerate

  assign head_in   = ring_q[0];
  assign out_free  = !out_valid || m_tready;
  assign owner_hit = head_in.used && (head_in.owner == req_owner);
  assign age       = req_now - head_in.deadline;
  assign due       = owner_hit && !age[31];
  assign id_take   = (next_id == 32'd0) ? 32'd1 : next_id;

  always_comb begin
    head_out        = head_in;
    advance         = 1'b1;
    done_next       = done;
    next_id_next    = next_id;
    res_id_next     = res_id;
    out_load        = 1'b0;
    out_kind_next   = out_kind;
    out_id_next     = out_id;
    out_cb_next     = out_cb;
    out_user_next   = out_user;
    out_status_next = out_status;
    out_last_next   = out_last;
    state_next      = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
          done_next  = 1'b0;
        end
      end
      ST_SCAN: begin
        case (req_action)
          ACT_SET: begin
            if (req_ok && !done && !head_in.used) begin
              head_out.used     = 1'b1;
              head_out.owner    = req_owner;
              head_out.id       = id_take;
              head_out.delay    = req_delay;
              head_out.deadline = req_now + req_delay;
              head_out.callback = req_callback;
              head_out.user     = req_user;
              head_out.periodic = req_periodic;
              done_next         = 1'b1;
              res_id_next       = id_take;
              next_id_next      = id_take + 32'd1;
            end
          end
          ACT_KILL: begin
            if (!done && owner_hit && (head_in.id == req_target)) begin
              head_out  = '0;
              done_next = 1'b1;
            end
          end
          ACT_POLL: begin
            if (due) begin
              advance = out_free;
              if (out_free) begin
                out_load        = 1'b1;
                out_kind_next   = KIND_FIRE;
                out_id_next     = head_in.id;
                out_cb_next     = head_in.callback;
                out_user_next   = head_in.user;
                out_status_next = 1'b0;
                out_last_next   = 1'b0;
                if (head_in.periodic) begin
                  head_out.deadline = req_now + head_in.delay;
                end else begin
                  head_out = '0;
                end
              end
            end
          end
          ACT_CLEANUP: begin
            if (owner_hit) begin
              head_out = '0;
            end
          end
          default: begin
          end
        endcase
        if (advance && (count == CNT_W'(TIMER_SLOTS - 1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_id_next     = 32'd0;
          out_cb_next     = 32'd0;
          out_user_next   = 32'd0;
          out_status_next = 1'b0;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
          case (req_action)
            ACT_SET: begin
              out_kind_next   = KIND_SET;
              out_id_next     = done ? res_id : 32'd0;
              out_status_next = !done;
            end
            ACT_KILL: begin
              out_kind_next   = KIND_KILL;
              out_status_next = !done;
            end
            ACT_POLL: begin
              out_kind_next = KIND_POLL_DONE;
            end
            ACT_CLEANUP: begin
              out_kind_next = KIND_CLEANUP;
            end
            default: begin
              out_kind_next = KIND_CLEANUP;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign shift = (state == ST_SCAN) && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      done      <= 1'b0;
      next_id   <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      next_id <= next_id_next;
      if (state == ST_IDLE) begin
        count <= '0;
      end else if (shift) begin
        count <= count + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_id <= res_id_next;
    if (s_tvalid && s_tready) begin
      req_action   <= s_tuser;
      req_owner    <= s_tdata[15:0];
      req_now      <= s_tdata[47:16];
      req_delay    <= s_tdata[79:48];
      req_periodic <= s_tdata[80];
      req_callback <= s_tdata[112:81];
      req_user     <= s_tdata[144:113];
      req_target   <= s_tdata[176:145];
      req_ok       <= (s_tdata[79:48] != 32'd0) && (s_tdata[112:81] != 32'd0);
    end
    if (out_load) begin
      out_kind   <= out_kind_next;
      out_id     <= out_id_next;
      out_cb     <= out_cb_next;
      out_user   <= out_user_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_status, out_user, out_cb, out_id};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_FIRE)) |-> !m_tlast)
    else $error("fire item marked last");

  a_idle_no_shift: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !shift)
    else $error("ring shifted while idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SCAN) && (count == '0))
    else $error("accepted item did not start a scan");

  a_fire_only_poll: assert property (@(posedge clk) disable iff (rst)
    out_load && (out_kind_next == KIND_FIRE) |-> (req_action == ACT_POLL))
    else $error("fire outside poll");

endmodule
